// File: hdl/gcsw_pkg.sv
// Package for the granule chain size walker.
// Holds the payload structs, the end reason and opcode codes, and the
// controller-to-datapath command and status types. No dependencies.
package gcsw_pkg;

  // Link byte markers in the granule table.
  localparam logic [7:0] LastMin  = 8'hC0;
  localparam logic [7:0] LastMax  = 8'hC9;
  localparam logic [7:0] FreeMark = 8'hFF;

  // Bytes in one sector, and the largest byte size a result can report.
  localparam int unsigned SectorBytes = 256;
  localparam int unsigned ByteSizeMax = 262143;

  // Input opcodes.
  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_MEASURE = 1'b1
  } opcode_e;

  // Why a walk ended.
  typedef enum logic [1:0] {
    REASON_LAST  = 2'd0,
    REASON_FREE  = 2'd1,
    REASON_RANGE = 2'd2,
    REASON_LIMIT = 2'd3
  } reason_e;

  // Which size value the datapath keeps when a walk ends.
  typedef enum logic [1:0] {
    SIZE_ACC  = 2'd0,
    SIZE_STEP = 2'd1,
    SIZE_LAST = 2'd2
  } size_sel_e;

  // One input item.
  typedef struct packed {
    logic        opcode;
    logic [6:0]  entry_index;
    logic [7:0]  entry_value;
    logic [7:0]  first_gran;
    logic [15:0] last_bytes;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [6:0]  granule_count;
    logic [17:0] byte_size;
    logic [9:0]  sector_count;
    logic [1:0]  end_reason;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      write;     // store the input link byte in the table
    logic      load;      // capture a measure item and clear the walk state
    logic      read;      // read the table at the current granule, count it
    logic      use_link;  // current granule is the last link read
    logic      acc_add;   // add one full granule to the size accumulator
    logic      finish;    // capture the end reason and size
    size_sel_e size_sel;
    reason_e   reason;
    logic      publish;   // move the captured result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gran_oor;   // current granule is outside the table
    logic count_lim;  // granule count has reached the table size
    logic link_last;  // last link read is a last-granule marker
    logic link_free;  // last link read is the free marker
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

// File: hdl/gcsw_datapath.sv
// Datapath of the granule chain size walker: link table memory, walk
// registers, size arithmetic, result capture and output register.
// Depends on gcsw_pkg.
module gcsw_datapath #(
  parameter int unsigned GRANULE_COUNT = 68,
  parameter int unsigned GRAN_SECTORS  = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcsw_pkg::in_item_t  in_item_i,
  input  gcsw_pkg::cmd_t      cmd_i,
  output gcsw_pkg::status_t   status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gcsw_pkg::out_item_t out_item_o
);
  import gcsw_pkg::*;

  localparam int unsigned AddrW  = (GRANULE_COUNT > 1) ? $clog2(GRANULE_COUNT) : 1;
  localparam int unsigned CntW   = $clog2(GRANULE_COUNT + 1);
  localparam int unsigned GBytes = GRAN_SECTORS * SectorBytes;
  localparam int unsigned AccRaw = $clog2(GRANULE_COUNT * GBytes + 65536 + 1) + 1;
  localparam int unsigned AccW   = (AccRaw > 20) ? AccRaw : 20;

  // Link table; contents are undefined until written.
  logic [7:0] link_mem [GRANULE_COUNT];

  logic [7:0]             link_q;
  logic [7:0]             start_q;
  logic [15:0]            lastb_q;
  logic [CntW-1:0]        count_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] res_size_q;
  reason_e                res_reason_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic [7:0]             cur_gran;
  logic [3:0]             link_secs;
  logic signed [AccW-1:0] term_last;
  logic signed [AccW-1:0] size_step;
  logic signed [AccW-1:0] size_last;
  logic signed [AccW-1:0] size_pick;
  logic [17:0]            size_sat;
  logic                   wr_in_range;

  // The granule under test is the start granule or the link just read.
  assign cur_gran    = cmd_i.use_link ? link_q : start_q;
  assign wr_in_range = ({1'b0, in_item_i.entry_index} < 8'(GRANULE_COUNT));

  // Table writes and registered link reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_in_range) begin
      link_mem[AddrW'({1'b0, in_item_i.entry_index})] <= in_item_i.entry_value;
    end
    if (cmd_i.read) begin
      link_q <= link_mem[AddrW'(cur_gran)];
    end
  end

  // Status toward the controller.
  assign status_o.gran_oor  = (cur_gran >= 8'(GRANULE_COUNT));
  assign status_o.count_lim = (count_q >= CntW'(GRANULE_COUNT));
  assign status_o.link_last = (link_q >= LastMin) && (link_q <= LastMax);
  assign status_o.link_free = (link_q == FreeMark);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Size of a chain that ends on a last-granule marker.
  assign link_secs = 4'(link_q - LastMin);
  always_comb begin
    term_last = AccW'({link_secs, 8'h00});
    if (lastb_q != '0) begin
      term_last = term_last + AccW'(lastb_q) - AccW'(SectorBytes);
    end
  end
  assign size_step = acc_q + AccW'(GBytes);
  assign size_last = acc_q + term_last;

  always_comb begin
    case (cmd_i.size_sel)
      SIZE_STEP: size_pick = size_step;
      SIZE_LAST: size_pick = size_last;
      default:   size_pick = acc_q;
    endcase
  end

  // Walk state: start granule, last-sector bytes, count and size.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= in_item_i.first_gran;
      lastb_q <= in_item_i.last_bytes;
      count_q <= '0;
      acc_q   <= '0;
    end else begin
      if (cmd_i.read) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.acc_add) begin
        acc_q <= size_step;
      end
    end
    if (cmd_i.finish) begin
      res_size_q   <= size_pick;
      res_reason_q <= cmd_i.reason;
    end
  end

  // Clamp the captured size into the result range.
  always_comb begin
    if (res_size_q < 0) begin
      size_sat = '0;
    end else if (res_size_q > $signed(AccW'(ByteSizeMax))) begin
      size_sat = 18'(ByteSizeMax);
    end else begin
      size_sat = 18'(res_size_q);
    end
  end

  // Output register; a result waits here until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.granule_count <= 7'(count_q);
      out_q.byte_size     <= size_sat;
      out_q.sector_count  <= 10'(count_q * GRAN_SECTORS);
      out_q.end_reason    <= res_reason_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/gcsw_ctrl.sv
// Controller of the granule chain size walker: a one-hot state machine
// that sequences table writes, the chain walk and result hand-off.
// Depends on gcsw_pkg.
module gcsw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_measure_i,
  output logic              in_ready_o,
  input  gcsw_pkg::status_t status_i,
  output gcsw_pkg::cmd_t    cmd_o
);
  import gcsw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIRST = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.size_sel = SIZE_ACC;
    cmd_o.reason   = REASON_RANGE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_measure_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_FIRST;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      // Check the start granule and read its link.
      ST_FIRST: begin
        if (status_i.gran_oor) begin
          cmd_o.finish = 1'b1;
          cmd_o.reason = REASON_RANGE;
          state_d      = ST_DONE;
        end else if (status_i.count_lim) begin
          cmd_o.finish = 1'b1;
          cmd_o.reason = REASON_LIMIT;
          state_d      = ST_DONE;
        end else begin
          cmd_o.read = 1'b1;
          state_d    = ST_WALK;
        end
      end
      // Judge the link just read; follow it with the next read when it continues.
      ST_WALK: begin
        cmd_o.use_link = 1'b1;
        if (status_i.link_last) begin
          cmd_o.finish   = 1'b1;
          cmd_o.reason   = REASON_LAST;
          cmd_o.size_sel = SIZE_LAST;
          state_d        = ST_DONE;
        end else if (status_i.link_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.reason = REASON_FREE;
          state_d      = ST_DONE;
        end else begin
          cmd_o.acc_add = 1'b1;
          if (status_i.gran_oor) begin
            cmd_o.finish   = 1'b1;
            cmd_o.reason   = REASON_RANGE;
            cmd_o.size_sel = SIZE_STEP;
            state_d        = ST_DONE;
          end else if (status_i.count_lim) begin
            cmd_o.finish   = 1'b1;
            cmd_o.reason   = REASON_LIMIT;
            cmd_o.size_sel = SIZE_STEP;
            state_d        = ST_DONE;
          end else begin
            cmd_o.read = 1'b1;
          end
        end
      end
      // Hand the result to the output register once it has room.
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/granule_chain_size_walker.sv
// Top level of the granule chain size walker.
// Depends on gcsw_pkg, gcsw_ctrl and gcsw_datapath.
//
// A write item stores one link byte in the granule table; it gives no
// result. A measure item follows the chain from its start granule and reads
// at most GRANULE_COUNT links; its result waits in the controller while the
// output register is still held by an earlier result. The walk follows the
// table memory: one registered read per cycle, and each read address is the
// link byte returned by the read before it. A new item is taken once the
// previous measure has moved its result to the output register, so a waiting
// result does not block input.
module granule_chain_size_walker #(
  parameter int unsigned GRANULE_COUNT = 68,
  parameter int unsigned GRAN_SECTORS  = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gcsw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gcsw_pkg::out_item_t out_item_o
);
  import gcsw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing of writes, the walk and result hand-off.
  gcsw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_measure_i (in_item_i.opcode == OP_MEASURE),
    .in_ready_o   (in_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Table, walk registers and result path.
  gcsw_datapath #(
    .GRANULE_COUNT (GRANULE_COUNT),
    .GRAN_SECTORS  (GRAN_SECTORS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hdl/gcsw_checker.sv
// Port-level checker for the granule chain size walker, with the bind
// statement that attaches it to the top level. Depends on gcsw_pkg.
module gcsw_checker #(
  parameter int unsigned GRANULE_COUNT = 68,
  parameter int unsigned GRAN_SECTORS  = 9
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input gcsw_pkg::out_item_t out_item_o
);
  import gcsw_pkg::*;

  // Counts fit the seven-bit result field without wrapping.
  localparam bit NoWrap = (GRANULE_COUNT < 128);

  // A result stays offered until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed before its transfer");

  // A new result never appears while input is being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a walk in progress");

  // Sector count follows the granule count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NoWrap |->
      out_item_o.sector_count == 10'(out_item_o.granule_count * GRAN_SECTORS))
    else $error("sector count does not match granule count");

  // A walk that ends on a marker has visited at least one granule.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NoWrap &&
    (out_item_o.end_reason == REASON_LAST || out_item_o.end_reason == REASON_FREE) |->
      out_item_o.granule_count != '0)
    else $error("marker end with no granule counted");

  // A walk that visited nothing has no size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NoWrap && out_item_o.granule_count == '0 |->
      out_item_o.byte_size == '0 && out_item_o.end_reason == REASON_RANGE)
    else $error("empty walk with nonzero size or wrong reason");

endmodule

bind granule_chain_size_walker gcsw_checker #(
  .GRANULE_COUNT (GRANULE_COUNT),
  .GRAN_SECTORS  (GRAN_SECTORS)
) u_gcsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
